// File: src/acm_pkg.sv
`timescale 1ns / 1ps

package acm_pkg;

	localparam int NUM_ANTS           = 8;
	localparam int ARCHIVE_LEN        = 8;
	localparam int WEIGHT_TABLE_DEPTH = 256;

	// register file: two archive banks, then the ant slots
	localparam int POOL_DEPTH = 2 * ARCHIVE_LEN + NUM_ANTS;
	localparam int PIDX_W     = $clog2(POOL_DEPTH);
	localparam int AIDX_W     = $clog2(ARCHIVE_LEN);
	localparam int WIDX_W     = $clog2(WEIGHT_TABLE_DEPTH);
	localparam int SUM_W      = 16 + $clog2(ARCHIVE_LEN + 1);
	localparam int NUM_W      = 32 + $clog2(WEIGHT_TABLE_DEPTH + 1);
	localparam int SPREAD_SH  = 12;

	localparam logic [9:0] THR_COEF = 10'd983;   // 0.015 * 65536

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLTAGE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_COUNT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPREAD       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_EVAPORATION  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PERTURB_FRAC = 3'd5;

	localparam logic [15:0] RST_MAX_VOLTAGE  = 16'd10240;
	localparam logic [7:0]  RST_ITER_COUNT   = 8'd20;
	localparam logic [15:0] RST_INIT_STEP    = 16'd256;
	localparam logic [15:0] RST_SPREAD       = 16'd256;
	localparam logic [15:0] RST_EVAPORATION  = 16'd655;
	localparam logic [15:0] RST_PERTURB_FRAC = 16'd6554;

	typedef struct packed {
		logic [15:0] voltage;
		logic [15:0] current;
		logic [15:0] random_first;
		logic [15:0] random_second;
	} acm_sample_t;

	typedef struct packed {
		logic [15:0] voltage_setpoint;
	} acm_result_t;

	typedef struct packed {
		logic [15:0] v;
		logic [31:0] p;
	} acm_entry_t;

	typedef struct packed {
		logic              we_v;
		logic              we_p;
		logic [PIDX_W-1:0] idx;
		acm_entry_t        e;
	} acm_wr_t;

	typedef logic [15:0] wtab_t [WEIGHT_TABLE_DEPTH];

	// exp(-8 i / depth) in Q0.16: series for exp(-y/16), squared four times
	function automatic logic [15:0] exp_neg_q16(input logic [63:0] num);
		logic [63:0] u;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] s;
		logic [63:0] q;
		u    = (num << 28) / WEIGHT_TABLE_DEPTH;
		term = 64'd1 << 32;
		sum  = term;
		for (int k = 1; k <= 14; k++) begin
			term = ((term * u) >> 32) / 64'(k);
			if (k[0]) sum = sum - term;
			else      sum = sum + term;
		end
		s = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
		for (int r = 0; r < 4; r++) s = (s * s) >> 32;
		q = (s + 64'd32768) >> 16;
		return (q > 64'd65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic wtab_t build_wtab();
		wtab_t t;
		for (int i = 0; i < WEIGHT_TABLE_DEPTH; i++) t[i] = exp_neg_q16(64'(8 * i));
		return t;
	endfunction

	localparam wtab_t WTAB = build_wtab();

endpackage

// File: src/acm_in_if.sv
`timescale 1ns / 1ps

interface acm_in_if;
	import acm_pkg::*;
	logic        valid;
	logic        ready;
	acm_sample_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/acm_out_if.sv
`timescale 1ns / 1ps

interface acm_out_if;
	import acm_pkg::*;
	logic        valid;
	logic        ready;
	acm_result_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/ant_colony_mppt_tracker_top.sv
`timescale 1ns / 1ps

// Ant colony MPPT tracker.
// sample: one transaction per control step carries the measured voltage and
//   current (Q8.8) and two uniform random fractions (Q0.16).
// setpoint: one transaction per sample with the next voltage setpoint (Q8.8).
// wr_en/wr_index/wr_data: register writes the user must make only in idle,
// not checked by the block. One sample at a time; ready is high only in idle.
// From the sample transaction to setpoint valid, all work runs through one
//   shared 20x17 multiplier and a sequencer; fill, hold, perturb and ant steps
//   differ in length (a weight division gives one quotient bit per cycle,
//   and the roulette walks the archive entries in turn).
//   The first ant of a round adds the archive swap-sort; the round end step
//   adds the ant sort.
// Reset clears the phase counters, best voltage, last power and loads the
// register reset values; archive and ant stores are written before use.
// A finished result waits in the output register; if the receiver stalls
// a second result waits until the first is taken.
module ant_colony_mppt_tracker_top (
	input  logic                        clk,
	input  logic                        arst_n,
	acm_in_if.sink                      sample,
	acm_out_if.source                   setpoint,
	input  logic                        wr_en,
	input  logic [acm_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [15:0]                 wr_data
);
	import acm_pkg::*;

	localparam int FILL_W = $clog2(ARCHIVE_LEN + 2);
	localparam int ANT_W  = $clog2(NUM_ANTS + 1);
	localparam int MAXN   = (ARCHIVE_LEN > NUM_ANTS) ? ARCHIVE_LEN : NUM_ANTS;
	localparam int SIDX_W = $clog2(MAXN);
	localparam int MI_W   = $clog2(ARCHIVE_LEN + 1);
	localparam int MB_W   = $clog2(NUM_ANTS + 1);
	localparam int BIT_W  = $clog2(WIDX_W);
	localparam int MUL_W  = SUM_W + 17;
	localparam logic [PIDX_W-1:0] TBASE = PIDX_W'(2 * ARCHIVE_LEN);

	typedef enum logic [4:0] {
		ST_IDLE, ST_PWR, ST_DISP, ST_FILL, ST_BR,
		ST_SLD, ST_SCMP, ST_SWB,
		ST_CA0, ST_CD, ST_CQ, ST_CDIV, ST_CW, ST_CR1, ST_CR2, ST_CROUL, ST_CDX,
		ST_MLA, ST_MLB, ST_MG, ST_RND, ST_RND2,
		ST_HTHR, ST_PT1, ST_PT2, ST_OUT
	} state_t;

	state_t state_q;

	// configuration
	logic [15:0] max_v_q, init_sw_q, spread_q, evap_q, pfrac_q;
	logic [7:0]  iter_q;

	// phase state
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        round_q;
	logic [ANT_W-1:0]  ant_q;
	logic [AIDX_W-1:0] ri_q;
	logic              ract_q;
	logic [15:0]       best_q, sw_q;
	logic [31:0]       last_q;
	logic              bank_q;

	// working registers
	acm_sample_t       in_q;
	logic [31:0]       p_q;
	logic              sort_ant_q;
	logic [SIDX_W-1:0] si_q, sj_q;
	acm_entry_t        cur_q, cur_a_q, cur_b_q;
	logic [15:0]       av0_q;
	logic [AIDX_W-1:0] k_q, ref_q;
	logic [SUM_W-1:0]  sum_q, cumul_q;
	logic [NUM_W-1:0]  rem_q;
	logic [WIDX_W-1:0] q_q;
	logic [BIT_W-1:0]  bit_q;
	logic [SUM_W+15:0] rs_q;
	logic [MI_W-1:0]   ma_q, mi_q;
	logic [MB_W-1:0]   mb_q;
	logic [15:0]       res_q;
	logic              out_v_q;
	logic [15:0]       out_d_q;
	logic [MUL_W-1:0]  mul_q;
	logic [15:0]       wt_q [ARCHIVE_LEN];

	// shared multiplier and store ports
	logic [SUM_W-1:0]  mul_a;
	logic [16:0]       mul_b;
	logic [PIDX_W-1:0] rd_idx;
	acm_entry_t        rd;
	acm_wr_t           wr;
	logic              wt_we;
	logic [15:0]       wt_val;

	acm_store u_store (
		.clk     (clk),
		.rd_idx  (rd_idx),
		.rd_data (rd),
		.wr      (wr)
	);

	logic [PIDX_W-1:0] abase, nbase, sbase;
	logic [SIDX_W-1:0] slast;
	assign abase = bank_q ? PIDX_W'(ARCHIVE_LEN) : '0;
	assign nbase = bank_q ? '0 : PIDX_W'(ARCHIVE_LEN);
	assign sbase = sort_ant_q ? TBASE : abase;
	assign slast = sort_ant_q ? SIDX_W'(NUM_ANTS - 1) : SIDX_W'(ARCHIVE_LEN - 1);

	logic accept;
	assign accept         = sample.valid && sample.ready;
	assign sample.ready   = (state_q == ST_IDLE);
	assign setpoint.valid = out_v_q;
	assign setpoint.data.voltage_setpoint = out_d_q;

	// datapath pieces
	logic [15:0] sp_eff;
	logic [27:0] den;
	logic [NUM_W-1:0] trial;
	logic [16:0] dsub;
	logic [15:0] absd;
	logic        div_zero;
	logic [16:0] dx_hi;
	logic [18:0] cand_s;
	logic [15:0] cand;
	logic        swap;
	logic        take_b;
	logic [MB_W-1:0] mb_n;
	logic [AIDX_W-1:0] ref_n;
	logic        roul_go;
	logic        last_k;
	logic [17:0] thr;
	logic [31:0] dmag;
	logic        act;
	logic [15:0] delta;
	logic [16:0] pt_up, pt_t0;
	logic [15:0] pt_dn, pt;

	assign sp_eff   = (spread_q == '0) ? 16'd1 : spread_q;
	assign den      = {sp_eff, {SPREAD_SH{1'b0}}};
	assign trial    = NUM_W'(den) << bit_q;
	assign dsub     = {1'b0, av0_q} - {1'b0, rd.v};
	assign absd     = dsub[16] ? 16'(-dsub) : dsub[15:0];
	assign div_zero = mul_q[31:0] >= {4'b0, den};
	assign dx_hi    = mul_q[31:15];
	assign cand_s   = {3'b0, rd.v} + {2'b0, dx_hi} - {3'b0, sw_q};
	assign cand     = cand_s[18] ? 16'd0 : (cand_s[16] ? 16'hFFFF : cand_s[15:0]);
	assign swap     = cur_q.p < rd.p;
	assign take_b   = (mb_q < MB_W'(NUM_ANTS)) && !(cur_a_q.p > cur_b_q.p);
	assign mb_n     = mb_q + 1'b1;
	assign ref_n    = (ref_q == AIDX_W'(ARCHIVE_LEN - 1)) ? '0 : ref_q + 1'b1;
	assign roul_go  = (ref_q < AIDX_W'(ARCHIVE_LEN - 1)) && (rs_q >= {cumul_q, 16'b0});
	assign last_k   = (k_q == AIDX_W'(ARCHIVE_LEN - 1));
	assign thr      = mul_q[25:8];
	assign dmag     = (p_q > last_q) ? p_q - last_q : last_q - p_q;
	assign act      = ract_q || (dmag > 32'(thr));
	assign delta    = mul_q[31:16];
	assign pt_up    = {1'b0, rd.v} + {1'b0, delta};
	assign pt_dn    = (rd.v >= delta) ? rd.v - delta : 16'd0;
	assign pt_t0    = in_q.random_second[15] ? {1'b0, pt_dn} : pt_up;
	assign pt       = (pt_t0 > {1'b0, max_v_q}) ? max_v_q : pt_t0[15:0];

	// operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_PWR: begin
				mul_a = SUM_W'(in_q.voltage);
				mul_b = {1'b0, in_q.current};
			end
			ST_DISP: begin
				mul_a = SUM_W'(max_v_q);
				mul_b = {1'b0, in_q.random_first};
			end
			ST_BR: begin
				mul_a = SUM_W'(max_v_q);
				mul_b = 17'(THR_COEF);
			end
			ST_CD: begin
				mul_a = SUM_W'(absd);
				mul_b = {1'b0, absd};
			end
			ST_CR1: begin
				mul_a = sum_q;
				mul_b = {1'b0, in_q.random_first};
			end
			ST_CROUL: begin
				mul_a = SUM_W'(sw_q);
				mul_b = {1'b0, in_q.random_second};
			end
			ST_RND: begin
				mul_a = SUM_W'(sw_q);
				mul_b = 17'h10000 - {1'b0, evap_q};
			end
			ST_HTHR: begin
				mul_a = SUM_W'(pfrac_q);
				mul_b = {1'b0, max_v_q};
			end
			ST_PT1: begin
				mul_a = SUM_W'(mul_q[31:16]);
				mul_b = {1'b0, in_q.random_first};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) mul_q <= mul_a * mul_b;

	// store addressing
	always_comb begin
		rd_idx = abase;
		wr     = '0;
		wt_we  = 1'b0;
		wt_val = '0;
		case (state_q)
			ST_DISP: begin
				wr.e.p = mul_q[31:0];
				if (fill_q < FILL_W'(ARCHIVE_LEN)) begin
					wr.we_p = (fill_q != '0);
					wr.idx  = abase + PIDX_W'(fill_q) - 1'b1;
				end else if (fill_q == FILL_W'(ARCHIVE_LEN)) begin
					wr.we_p = 1'b1;
					wr.idx  = abase + PIDX_W'(ARCHIVE_LEN - 1);
				end
			end
			ST_FILL: begin
				wr.we_v = 1'b1;
				wr.idx  = abase + PIDX_W'(fill_q);
				wr.e.v  = mul_q[31:16];
			end
			ST_BR: begin
				wr.we_p = (round_q < iter_q) && (ant_q != '0);
				wr.idx  = TBASE + PIDX_W'(ant_q) - 1'b1;
				wr.e.p  = p_q;
			end
			ST_SLD: rd_idx = sbase + PIDX_W'(si_q);
			ST_SCMP: begin
				rd_idx  = sbase + PIDX_W'(sj_q);
				wr.we_v = swap;
				wr.we_p = swap;
				wr.idx  = sbase + PIDX_W'(sj_q);
				wr.e    = cur_q;
			end
			ST_SWB: begin
				wr.we_v = 1'b1;
				wr.we_p = 1'b1;
				wr.idx  = sbase + PIDX_W'(si_q);
				wr.e    = cur_q;
			end
			ST_CD: rd_idx = abase + PIDX_W'(k_q);
			ST_CQ: begin
				wt_we  = div_zero;
				wt_val = '0;
			end
			ST_CW: begin
				wt_we  = 1'b1;
				wt_val = WTAB[q_q];
			end
			ST_CDX: begin
				rd_idx  = abase + PIDX_W'(ref_q);
				wr.we_v = 1'b1;
				wr.idx  = TBASE + PIDX_W'(ant_q);
				wr.e.v  = cand;
			end
			ST_MLB: rd_idx = TBASE;
			ST_MG: begin
				if (take_b)
					rd_idx = (mb_n < MB_W'(NUM_ANTS)) ? TBASE + PIDX_W'(mb_n) : TBASE;
				else
					rd_idx = abase + PIDX_W'(ma_q) + 1'b1;
				wr.we_v = (mi_q != MI_W'(ARCHIVE_LEN));
				wr.we_p = (mi_q != MI_W'(ARCHIVE_LEN));
				wr.idx  = nbase + PIDX_W'(mi_q);
				wr.e    = take_b ? cur_b_q : cur_a_q;
			end
			ST_HTHR: begin
				wr.we_p = act && (ri_q != '0);
				wr.idx  = abase + PIDX_W'(ri_q) - 1'b1;
				wr.e.p  = p_q;
			end
			ST_PT2: begin
				rd_idx  = abase + PIDX_W'(ri_q);
				wr.we_v = 1'b1;
				wr.idx  = abase + PIDX_W'(ri_q);
				wr.e.v  = pt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wt_we) wt_q[k_q] <= wt_val;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			max_v_q   <= RST_MAX_VOLTAGE;
			iter_q    <= RST_ITER_COUNT;
			init_sw_q <= RST_INIT_STEP;
			spread_q  <= RST_SPREAD;
			evap_q    <= RST_EVAPORATION;
			pfrac_q   <= RST_PERTURB_FRAC;
			fill_q    <= '0;
			round_q   <= '0;
			ant_q     <= '0;
			ri_q      <= '0;
			ract_q    <= 1'b0;
			best_q    <= '0;
			last_q    <= '0;
			sw_q      <= RST_INIT_STEP;
			bank_q    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					CFG_MAX_VOLTAGE:  max_v_q   <= wr_data;
					CFG_ITER_COUNT:   iter_q    <= wr_data[7:0];
					CFG_INIT_STEP:    init_sw_q <= wr_data;
					CFG_SPREAD:       spread_q  <= wr_data;
					CFG_EVAPORATION:  evap_q    <= wr_data;
					CFG_PERTURB_FRAC: pfrac_q   <= wr_data;
					default: ;
				endcase
			end
			if (out_v_q && setpoint.ready) out_v_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						in_q    <= sample.data;
						state_q <= ST_PWR;
					end
				end
				ST_PWR: state_q <= ST_DISP;
				ST_DISP: begin
					p_q <= mul_q[31:0];
					if (fill_q < FILL_W'(ARCHIVE_LEN)) begin
						state_q <= ST_FILL;
					end else begin
						if (fill_q == FILL_W'(ARCHIVE_LEN)) fill_q <= fill_q + 1'b1;
						state_q <= ST_BR;
					end
				end
				ST_FILL: begin
					res_q   <= mul_q[31:16];
					fill_q  <= fill_q + 1'b1;
					state_q <= ST_OUT;
				end
				ST_BR: begin
					if (round_q < iter_q) begin
						si_q <= '0;
						if (ant_q == '0) begin
							sort_ant_q <= 1'b0;
							state_q    <= ST_SLD;
						end else if (ant_q < ANT_W'(NUM_ANTS)) begin
							state_q <= ST_CA0;
						end else begin
							sort_ant_q <= 1'b1;
							state_q    <= ST_SLD;
						end
					end else begin
						state_q <= ST_HTHR;
					end
				end
				// swap-sort: hold entry i, sweep j over the rest
				ST_SLD: begin
					cur_q   <= rd;
					sj_q    <= si_q + 1'b1;
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					if (swap) cur_q <= rd;
					if (sj_q == slast) state_q <= ST_SWB;
					else sj_q <= sj_q + 1'b1;
				end
				ST_SWB: begin
					if (si_q == slast - 1'b1)
						state_q <= sort_ant_q ? ST_MLA : ST_CA0;
					else begin
						si_q    <= si_q + 1'b1;
						state_q <= ST_SLD;
					end
				end
				// candidate: weights, roulette, random step
				ST_CA0: begin
					av0_q   <= rd.v;
					k_q     <= '0;
					sum_q   <= '0;
					state_q <= ST_CD;
				end
				ST_CD: state_q <= ST_CQ;
				ST_CQ: begin
					if (div_zero) begin
						if (last_k) state_q <= ST_CR1;
						else begin
							k_q     <= k_q + 1'b1;
							state_q <= ST_CD;
						end
					end else begin
						rem_q   <= NUM_W'(mul_q[31:0]) * NUM_W'(WEIGHT_TABLE_DEPTH);
						q_q     <= '0;
						bit_q   <= BIT_W'(WIDX_W - 1);
						state_q <= ST_CDIV;
					end
				end
				ST_CDIV: begin
					if (rem_q >= trial) begin
						rem_q        <= rem_q - trial;
						q_q[bit_q]   <= 1'b1;
					end
					if (bit_q == '0) state_q <= ST_CW;
					else bit_q <= bit_q - 1'b1;
				end
				ST_CW: begin
					sum_q <= sum_q + SUM_W'(WTAB[q_q]);
					if (last_k) state_q <= ST_CR1;
					else begin
						k_q     <= k_q + 1'b1;
						state_q <= ST_CD;
					end
				end
				ST_CR1: begin
					ref_q   <= '0;
					cumul_q <= SUM_W'(wt_q[0]);
					state_q <= ST_CR2;
				end
				ST_CR2: begin
					rs_q    <= mul_q[SUM_W+15:0];
					state_q <= ST_CROUL;
				end
				ST_CROUL: begin
					if (roul_go) begin
						ref_q   <= ref_n;
						cumul_q <= cumul_q + SUM_W'(wt_q[ref_n]);
					end else begin
						state_q <= ST_CDX;
					end
				end
				ST_CDX: begin
					res_q   <= cand;
					ant_q   <= ant_q + 1'b1;
					state_q <= ST_OUT;
				end
				// merge sorted archive and ants into the other bank
				ST_MLA: begin
					cur_a_q <= rd;
					ma_q    <= '0;
					mi_q    <= '0;
					mb_q    <= '0;
					state_q <= ST_MLB;
				end
				ST_MLB: begin
					cur_b_q <= rd;
					state_q <= ST_MG;
				end
				ST_MG: begin
					if (mi_q == MI_W'(ARCHIVE_LEN)) begin
						bank_q  <= ~bank_q;
						state_q <= ST_RND;
					end else begin
						if (take_b) begin
							cur_b_q <= rd;
							mb_q    <= mb_n;
						end else begin
							cur_a_q <= rd;
							ma_q    <= ma_q + 1'b1;
						end
						mi_q <= mi_q + 1'b1;
					end
				end
				ST_RND: state_q <= ST_RND2;
				ST_RND2: begin
					sw_q    <= mul_q[31:16];
					round_q <= round_q + 1'b1;
					ant_q   <= '0;
					best_q  <= rd.v;
					last_q  <= rd.p;
					res_q   <= rd.v;
					state_q <= ST_OUT;
				end
				// hold, and archive perturbation on a power jump
				ST_HTHR: begin
					if (act) begin
						ract_q  <= 1'b1;
						state_q <= ST_PT1;
					end else begin
						res_q   <= best_q;
						state_q <= ST_OUT;
					end
				end
				ST_PT1: state_q <= ST_PT2;
				ST_PT2: begin
					res_q <= pt;
					if (ri_q < AIDX_W'(ARCHIVE_LEN - 1)) begin
						ri_q <= ri_q + 1'b1;
					end else begin
						round_q <= '0;
						ant_q   <= '0;
						sw_q    <= init_sw_q;
						ri_q    <= '0;
						ract_q  <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_v_q || setpoint.ready) begin
						out_v_q <= 1'b1;
						out_d_q <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// perturbation index only moves while a perturbation runs
	a_reinit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ract_q |-> (ri_q == '0))
		else $error("reinit index set while no perturbation is active");

	// merge never consumes more entries than it has written
	a_merge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MG) |-> (ma_q <= mi_q) && (MI_W'(mb_q) <= mi_q))
		else $error("merge read pointers ran ahead of write pointer");

	// one sample at a time: no transaction right after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !sample.ready)
		else $error("sample accepted while previous one still in work");
`endif

endmodule

// File: src/acm_store.sv
`timescale 1ns / 1ps

// archive banks and ant slots: one read, one write (voltage and power lanes)
module acm_store (
	input  logic                     clk,
	input  logic [acm_pkg::PIDX_W-1:0] rd_idx,
	output acm_pkg::acm_entry_t      rd_data,
	input  acm_pkg::acm_wr_t         wr
);
	import acm_pkg::*;

	acm_entry_t mem [POOL_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.we_v) mem[wr.idx].v <= wr.e.v;
		if (wr.we_p) mem[wr.idx].p <= wr.e.p;
	end

	assign rd_data = mem[rd_idx];

endmodule
